FILE: sv/periodic_can_frame_scheduler_macros.svh
// Assertion macros for the periodic CAN frame scheduler.
`ifndef PERIODIC_CAN_FRAME_SCHEDULER_MACROS_SVH
`define PERIODIC_CAN_FRAME_SCHEDULER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on clk_i, quiet during reset.
`define PCFS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pcfs: same-cycle check failed");
// Next-cycle implication.
`define PCFS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pcfs: next-cycle check failed");
`else
`define PCFS_ASSERT_IMP(lbl, ante, cons)
`define PCFS_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: sv/pcfs_pkg.sv
// Shared types, constants and slot tables of the periodic CAN frame scheduler.
package pcfs_pkg;

  localparam int ElapsedW  = 8;
  localparam int PeriodW   = 10;
  localparam int TimeW     = 16;
  localparam int IdW       = 11;
  localparam int DataW     = 64;
  localparam int CfgIdxW   = 3;
  localparam int SlotIdxW  = 4;
  localparam int NumRegs   = 7;
  localparam int InTdataW  = 8;
  localparam int OutTdataW = 80;

  localparam logic [IdW-1:0]     ID_ALIVE_NIBBLE = 11'h0b4;
  localparam logic [IdW-1:0]     ID_ALIVE_BYTE   = 11'h096;
  localparam logic [PeriodW-1:0] PERIOD_EXTRA    = 10'd10;

  typedef struct packed {
    logic signed [TimeW-1:0] rt;
    logic                    neg;
  } time_res_t;

  function automatic logic [IdW-1:0] slot_id(input logic [SlotIdxW-1:0] idx);
    logic [IdW-1:0] id;
    unique case (idx)
      4'd0:    id = 11'h248;
      4'd1:    id = 11'h096;
      4'd2:    id = 11'h12c;
      4'd3:    id = 11'h0b6;
      4'd4:    id = 11'h0b4;
      4'd5:    id = 11'h122;
      4'd6:    id = 11'h11c;
      default: id = '0;
    endcase
    return id;
  endfunction

  function automatic logic [PeriodW-1:0] period_reset(input logic [SlotIdxW-1:0] idx);
    logic [PeriodW-1:0] p;
    unique case (idx)
      4'd0:    p = 10'd100;
      4'd2:    p = 10'd20;
      default: p = 10'd10;
    endcase
    return p;
  endfunction

endpackage

FILE: sv/pcfs_time_unit.sv
// Shared remaining-time unit: saturating subtract of elapsed ms, sign flag.
module pcfs_time_unit (
  input  logic signed [pcfs_pkg::TimeW-1:0]    rt_i,
  input  logic        [pcfs_pkg::ElapsedW-1:0] dec_i,
  output pcfs_pkg::time_res_t                  res_o
);
  import pcfs_pkg::*;

  logic signed [TimeW:0] diff;

  assign diff = $signed({rt_i[TimeW-1], rt_i}) - $signed({{(TimeW+1-ElapsedW){1'b0}}, dec_i});

  always_comb begin
    // only underflow is possible; clamp to the most negative value
    if (diff[TimeW] != diff[TimeW-1]) begin
      res_o.rt = {1'b1, {(TimeW-1){1'b0}}};
    end else begin
      res_o.rt = diff[TimeW-1:0];
    end
    res_o.neg = res_o.rt[TimeW-1];
  end

endmodule

FILE: sv/periodic_can_frame_scheduler.sv
// Periodic CAN frame scheduler, top level: sequencer, slot state, output register.
//
// One input item is a scheduler tick (elapsed ms, power flag). The block is busy
// running every slot's remaining time through the shared saturating time unit,
// then, for a powered tick, walking the slots in list order, emitting one 8-byte
// frame per due slot. s_axis_tready is low while the block is busy, including
// every cycle in which a due frame waits for the output register to drain, so
// the next tick is accepted only once the walk is done.
// An unpowered tick still runs the time down but emits nothing. The result sits
// in an output register, so the next tick is taken while a frame waits. A slot
// is due if never sent or its time is below zero; it then reloads its period.
// Frame 0x0b4 carries a 4-bit alive count in bytes 0 and 7, frame 0x096 an
// 8-bit count in bytes 0 and 6. tlast marks the last frame of a tick. Periods
// are to be written through the cfg port only while the block is idle, which the
// block itself does not enforce; slots beyond the seventh have id 0 and a fixed 10 ms period.
module periodic_can_frame_scheduler #(
  parameter int SLOT_COUNT = 7
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // tick channel
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [pcfs_pkg::InTdataW-1:0]      s_axis_tdata,  // [7:0] elapsed_ms
  input  logic [0:0]                         s_axis_tuser,  // [0] powered
  // frame channel
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [pcfs_pkg::OutTdataW-1:0]     m_axis_tdata,  // [10:0] frame_id, [74:11] frame_data
  output logic                               m_axis_tlast,  // last_frame
  // period registers
  input  logic                               cfg_we_i,
  input  logic [pcfs_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [pcfs_pkg::PeriodW-1:0]       cfg_data_i
);
  import pcfs_pkg::*;

  localparam int SlotW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int RegCount = (SLOT_COUNT < NumRegs) ? SLOT_COUNT : NumRegs;
  localparam int RegW     = (RegCount > 1) ? $clog2(RegCount) : 1;

  typedef enum logic [1:0] {ST_IDLE, ST_SUB, ST_EMIT} state_e;

  state_e                    state_q;
  logic [SlotW-1:0]          slot_q;
  logic [ElapsedW-1:0]       elapsed_q;
  logic                      powered_q;
  logic [SLOT_COUNT-1:0]     due_q;
  logic [SLOT_COUNT-1:0]     sent_q;
  logic signed [TimeW-1:0]   rt_q [SLOT_COUNT];
  logic [PeriodW-1:0]        period_q [RegCount];
  logic [3:0]                nib_q;
  logic [7:0]                byte_q;

  logic                      out_valid_q;
  logic [IdW-1:0]            out_id_q;
  logic [DataW-1:0]          out_data_q;
  logic                      out_last_q;

  time_res_t                 tres;
  logic                      slot_last;
  logic                      higher_due;
  logic                      take;
  logic [IdW-1:0]            cur_id;
  logic [PeriodW-1:0]        cur_period;
  logic [3:0]                nib_d;
  logic [7:0]                byte_d;
  logic [DataW-1:0]          cur_data;
  logic                      tick_acc;

  pcfs_time_unit u_time (
    .rt_i  (rt_q[slot_q]),
    .dec_i (elapsed_q),
    .res_o (tres)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign tick_acc      = s_axis_tvalid && s_axis_tready;
  assign slot_last     = (slot_q == SlotW'(SLOT_COUNT - 1));
  assign cur_id        = slot_id(SlotIdxW'(slot_q));
  assign nib_d         = nib_q + 4'd1;
  assign byte_d        = byte_q + 8'd1;

  // emit only when the output register is free or draining this cycle
  assign take = (state_q == ST_EMIT) && due_q[slot_q] && (!out_valid_q || m_axis_tready);

  always_comb begin
    if (SlotIdxW'(slot_q) < SlotIdxW'(RegCount)) begin
      cur_period = period_q[slot_q[RegW-1:0]];
    end else begin
      cur_period = PERIOD_EXTRA;
    end
  end

  always_comb begin
    cur_data = '0;
    if (cur_id == ID_ALIVE_NIBBLE) begin
      cur_data[63:56] = {4'd0, nib_d};
      cur_data[7:0]   = {4'd0, nib_d};
    end else if (cur_id == ID_ALIVE_BYTE) begin
      cur_data[55:48] = byte_d;
      cur_data[7:0]   = byte_d;
    end
  end

  // any due slot further down the list decides tlast
  always_comb begin
    higher_due = 1'b0;
    for (int j = 0; j < SLOT_COUNT; j++) begin
      if ((SlotW'(j) > slot_q) && due_q[j]) begin
        higher_due = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_q      <= '0;
      elapsed_q   <= '0;
      powered_q   <= 1'b0;
      due_q       <= '0;
      sent_q      <= '0;
      nib_q       <= '0;
      byte_q      <= '0;
      out_valid_q <= 1'b0;
      out_id_q    <= '0;
      out_data_q  <= '0;
      out_last_q  <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        rt_q[i] <= '0;
      end
      for (int i = 0; i < RegCount; i++) begin
        period_q[i] <= period_reset(SlotIdxW'(i));
      end
    end else begin
      if (cfg_we_i && ({1'b0, cfg_idx_i} < (CfgIdxW+1)'(RegCount))) begin
        period_q[cfg_idx_i[RegW-1:0]] <= cfg_data_i;
      end

      if (take) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (tick_acc) begin
            elapsed_q <= s_axis_tdata[ElapsedW-1:0];
            powered_q <= s_axis_tuser[0];
            slot_q    <= '0;
            state_q   <= ST_SUB;
          end
        end
        ST_SUB: begin
          rt_q[slot_q]  <= tres.rt;
          due_q[slot_q] <= powered_q && (!sent_q[slot_q] || tres.neg);
          if (slot_last) begin
            slot_q  <= '0;
            state_q <= powered_q ? ST_EMIT : ST_IDLE;
          end else begin
            slot_q <= slot_q + 1'b1;
          end
        end
        ST_EMIT: begin
          if (take) begin
            rt_q[slot_q]   <= $signed({{(TimeW-PeriodW){1'b0}}, cur_period});
            sent_q[slot_q] <= 1'b1;
            due_q[slot_q]  <= 1'b0;
            out_id_q       <= cur_id;
            out_data_q     <= cur_data;
            out_last_q     <= !higher_due;
            if (cur_id == ID_ALIVE_NIBBLE) begin
              nib_q <= nib_d;
            end else if (cur_id == ID_ALIVE_BYTE) begin
              byte_q <= byte_d;
            end
          end
          if (take || !due_q[slot_q]) begin
            if (slot_last) begin
              slot_q  <= '0;
              state_q <= ST_IDLE;
            end else begin
              slot_q <= slot_q + 1'b1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {{(OutTdataW-DataW-IdW){1'b0}}, out_data_q, out_id_q};

`include "periodic_can_frame_scheduler_macros.svh"

  // every due flag is consumed before the sequencer goes idle again
  `PCFS_ASSERT_IMP(a_idle_no_due, state_q == ST_IDLE, due_q == '0)
  // a frame that is not the last of its tick means the walk is still going
  `PCFS_ASSERT_IMP(a_notlast_walk, out_valid_q && !out_last_q, state_q == ST_EMIT)
  // a loaded frame is presented on the next cycle
  `PCFS_ASSERT_NXT(a_take_valid, take, out_valid_q)

endmodule
